// ----- rtl/sgmpa_pkg.sv -----
// Shared definitions for the SGM path cost aggregator.
// Holds register indices, path kind codes, reset values and the path control struct.
// No dependencies.
`default_nettype none
package sgmpa_pkg;

  // Parameter defaults
  localparam int MAX_DISP_DEF = 128;
  localparam int MAX_COLS_DEF = 1024;

  // Field widths fixed by the stream format
  localparam int COST_W = 16;
  localparam int PATH_W = 17;
  localparam int SUM_W  = 20;
  localparam int CFG_W  = 13;
  localparam int ROW_W  = 12;

  localparam logic [SUM_W-1:0]  SUM_SAT  = '1;
  localparam logic [PATH_W-1:0] PATH_SAT = '1;

  // Configuration register indices
  localparam logic [2:0] REG_PATH_KIND  = 3'd0;
  localparam logic [2:0] REG_PENALTY_P1 = 3'd1;
  localparam logic [2:0] REG_PENALTY_P2 = 3'd2;
  localparam logic [2:0] REG_DISP_COUNT = 3'd3;
  localparam logic [2:0] REG_IMG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_IMG_HEIGHT = 3'd5;

  // Path kinds (predecessor pixel); the unused code behaves as previous column
  localparam logic [1:0] KIND_COL    = 2'd0;
  localparam logic [1:0] KIND_ROW    = 2'd1;
  localparam logic [1:0] KIND_DIAG   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Reset values of the registers
  localparam logic [1:0]  RST_KIND   = KIND_COL;
  localparam logic [9:0]  RST_P1     = 10'd4;
  localparam logic [9:0]  RST_P2     = 10'd32;
  localparam logic [7:0]  RST_DCOUNT = 8'd65;
  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [12:0] RST_HEIGHT = 13'd480;

  // Per-element control into the recurrence
  typedef struct packed {
    logic first;     // first pixel of the path: pass data cost through
    logic has_prev;  // disparity d-1 exists
    logic has_next;  // disparity d+1 exists
  } calc_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/sgmpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sgmpa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/sgmpa_path_calc.sv -----
// P1/P2 path cost recurrence for one element.
// Depends on sgmpa_pkg.
`default_nettype none
module sgmpa_path_calc (
  input  wire logic [sgmpa_pkg::COST_W-1:0] cost_in,
  input  wire logic [sgmpa_pkg::PATH_W-1:0] pred_same,
  input  wire logic [sgmpa_pkg::PATH_W-1:0] pred_next,
  input  wire logic [sgmpa_pkg::PATH_W-1:0] pred_prev,
  input  wire logic [sgmpa_pkg::PATH_W-1:0] pred_min,
  input  wire logic [9:0]                   p1,
  input  wire logic [9:0]                   p2,
  input  wire sgmpa_pkg::calc_ctl_t         ctl,
  output logic      [sgmpa_pkg::PATH_W-1:0] cost_out
);
  import sgmpa_pkg::*;

  logic [PATH_W:0]   best;
  logic [PATH_W:0]   cand_prev;
  logic [PATH_W:0]   cand_next;
  logic [PATH_W:0]   cand_jump;
  logic [PATH_W+1:0] sum;
  logic [PATH_W+1:0] diff;

  // Candidates with penalties
  assign cand_prev = {1'b0, pred_prev} + (PATH_W+1)'(p1);
  assign cand_next = {1'b0, pred_next} + (PATH_W+1)'(p1);
  assign cand_jump = {1'b0, pred_min} + (PATH_W+1)'(p2);

  always_comb begin
    best = {1'b0, pred_same};
    if (ctl.has_prev && cand_prev < best) best = cand_prev;
    if (ctl.has_next && cand_next < best) best = cand_next;
    if (cand_jump < best) best = cand_jump;
    sum  = (PATH_W+2)'(cost_in) + (PATH_W+2)'(best);
    diff = sum - (PATH_W+2)'(pred_min);
    // Clamp to zero below and to the field range above
    if (ctl.first) begin
      cost_out = PATH_W'(cost_in);
    end else if (sum < (PATH_W+2)'(pred_min)) begin
      cost_out = '0;
    end else if (diff > (PATH_W+2)'(PATH_SAT)) begin
      cost_out = PATH_SAT;
    end else begin
      cost_out = diff[PATH_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sgm_path_cost_aggregator_unit.sv -----
// SGM path cost aggregator: one pass, one element per beat.
// Data path: RAM read and stage register load on the accepting edge; the output register
// loads when the stage advances.
// Throughput: one element per cycle, set by the single read/modify/write per element;
// input stalls only while the output is held off with stage and output register full.
// Reset (rst, synchronous): registers to defaults, counters and sums cleared;
// the path cost stores hold no valid data until written by the stream.
// Depends on sgmpa_pkg, sgmpa_ram, sgmpa_path_calc.
`default_nettype none
module sgm_path_cost_aggregator_unit #(
  parameter int MAX_DISPARITIES = sgmpa_pkg::MAX_DISP_DEF,
  parameter int MAX_COLUMNS     = sgmpa_pkg::MAX_COLS_DEF,
  localparam int DW  = $clog2(MAX_DISPARITIES),
  localparam int OTW = ((37 + 2*DW + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // config write port
  input  wire logic                      cfg_we,
  input  wire logic [2:0]                cfg_addr,
  input  wire logic [sgmpa_pkg::CFG_W-1:0] cfg_data,
  // input stream
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [39:0]               s_tdata,  // match_cost[15:0], partial_sum[35:16]
  // output stream
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [OTW-1:0]                 m_tdata,  // path_cost, total_sum, disparity_index,
                                                   // best_disparity
  output logic                           m_tlast   // pixel_done
);
  import sgmpa_pkg::*;

  localparam int CW     = $clog2(MAX_COLUMNS);
  localparam int CADR_W = 1 + CW + DW;
  localparam int MADR_W = 1 + CW;

  // Configuration registers
  logic [1:0]  path_kind;
  logic [9:0]  p1;
  logic [9:0]  p2;
  logic [7:0]  dcount_cfg;
  logic [10:0] img_width;
  logic [12:0] img_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_kind  <= RST_KIND;
      p1         <= RST_P1;
      p2         <= RST_P2;
      dcount_cfg <= RST_DCOUNT;
      img_width  <= RST_WIDTH;
      img_height <= RST_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PATH_KIND:  path_kind  <= cfg_data[1:0];
        REG_PENALTY_P1: p1         <= cfg_data[9:0];
        REG_PENALTY_P2: p2         <= cfg_data[9:0];
        REG_DISP_COUNT: dcount_cfg <= cfg_data[7:0];
        REG_IMG_WIDTH:  img_width  <= cfg_data[10:0];
        REG_IMG_HEIGHT: img_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Scan position counters
  logic [DW-1:0]    dcnt;
  logic [CW-1:0]    ccnt;
  logic [ROW_W-1:0] rcnt;
  logic             cur_bank;

  logic [8:0]       cnt;
  logic [12:0]      wid;
  logic [12:0]      hgt;
  logic [DW-1:0]    d_cur;
  logic [CW-1:0]    col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             done;
  logic             last_col;
  logic             last_row;
  logic             first;
  logic             use_prior;
  logic [CW-1:0]    pcol;
  logic             rbank;
  logic             accept;

  // Clamp the settings and the counters
  always_comb begin
    cnt = {1'b0, dcount_cfg};
    if (cnt < 9'd2) cnt = 9'd2;
    else if (cnt > 9'(MAX_DISPARITIES)) cnt = 9'(MAX_DISPARITIES);
    wid = {2'b0, img_width};
    if (wid < 13'd1) wid = 13'd1;
    else if (wid > 13'(MAX_COLUMNS)) wid = 13'(MAX_COLUMNS);
    hgt = img_height;
    if (hgt < 13'd1) hgt = 13'd1;
    else if (hgt > 13'd4096) hgt = 13'd4096;
    d_cur   = (9'(dcnt) > cnt - 9'd1) ? DW'(cnt - 9'd1) : dcnt;
    col_cur = (13'(ccnt) > wid - 13'd1) ? CW'(wid - 13'd1) : ccnt;
    row_cur = (13'(rcnt) > hgt - 13'd1) ? ROW_W'(hgt - 13'd1) : rcnt;
    done     = (9'(d_cur) + 9'd1 >= cnt);
    last_col = (13'(col_cur) + 13'd1 >= wid);
    last_row = (13'(row_cur) + 13'd1 >= hgt);
    case (path_kind)
      KIND_ROW:  first = (row_cur == '0);
      KIND_DIAG: first = (row_cur == '0) || (col_cur == '0);
      default:   first = (col_cur == '0);
    endcase
    use_prior = (path_kind == KIND_ROW) || (path_kind == KIND_DIAG);
    pcol      = (path_kind == KIND_ROW) ? col_cur : col_cur - CW'(1);
    rbank     = use_prior ? ~cur_bank : cur_bank;
  end

  // Stage 1: element waiting on RAM read data
  logic                 s1_valid;
  logic                 s1_adv;
  logic [COST_W-1:0]    s1_cost;
  logic [SUM_W-1:0]     s1_partial;
  logic [DW-1:0]        s1_d;
  logic [CW-1:0]        s1_col;
  logic                 s1_bank;
  logic                 s1_done;
  logic                 s1_use_prior;
  calc_ctl_t            s1_ctl;
  logic [CADR_W-1:0]    s1_ra;
  logic [CADR_W-1:0]    s1_rb;
  logic [MADR_W-1:0]    s1_rm;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      dcnt     <= '0;
      ccnt     <= '0;
      rcnt     <= '0;
      cur_bank <= 1'b0;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (accept) begin
        if (!done) begin
          dcnt <= d_cur + DW'(1);
        end else begin
          dcnt <= '0;
          if (!last_col) begin
            ccnt <= col_cur + CW'(1);
          end else begin
            ccnt     <= '0;
            rcnt     <= last_row ? '0 : row_cur + ROW_W'(1);
            cur_bank <= ~cur_bank;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cost         <= s_tdata[15:0];
      s1_partial      <= s_tdata[35:16];
      s1_d            <= d_cur;
      s1_col          <= col_cur;
      s1_bank         <= cur_bank;
      s1_done         <= done;
      s1_use_prior    <= use_prior;
      s1_ctl.first    <= first;
      s1_ctl.has_prev <= (d_cur != '0);
      s1_ctl.has_next <= !done;
      s1_ra           <= {rbank, pcol, d_cur};
      s1_rb           <= {rbank, pcol, d_cur + DW'(1)};
      s1_rm           <= {~cur_bank, pcol};
    end
  end

  // RAM addressing: new element on accept, else hold for the stalled one
  logic [CADR_W-1:0] ra;
  logic [CADR_W-1:0] rb;
  logic [MADR_W-1:0] rm;
  logic [CADR_W-1:0] cost_waddr;
  logic [MADR_W-1:0] min_waddr;
  logic              min_we;
  logic [PATH_W-1:0] ram_a;
  logic [PATH_W-1:0] ram_b;
  logic [PATH_W-1:0] ram_m;
  logic [PATH_W-1:0] path;
  logic [PATH_W-1:0] rmin_new;

  assign ra = accept ? {rbank, pcol, d_cur} : s1_ra;
  assign rb = accept ? {rbank, pcol, d_cur + DW'(1)} : s1_rb;
  assign rm = accept ? {~cur_bank, pcol} : s1_rm;
  assign cost_waddr = {s1_bank, s1_col, s1_d};
  assign min_waddr  = {s1_bank, s1_col};
  assign min_we     = s1_adv && s1_done;

  // Two copies of the cost store give two read ports
  sgmpa_ram #(.WIDTH(PATH_W), .DEPTH(2**CADR_W)) u_cost_a (
    .clk(clk), .we(s1_adv), .waddr(cost_waddr), .wdata(path), .raddr(ra), .rdata(ram_a)
  );
  sgmpa_ram #(.WIDTH(PATH_W), .DEPTH(2**CADR_W)) u_cost_b (
    .clk(clk), .we(s1_adv), .waddr(cost_waddr), .wdata(path), .raddr(rb), .rdata(ram_b)
  );
  sgmpa_ram #(.WIDTH(PATH_W), .DEPTH(2**MADR_W)) u_min (
    .clk(clk), .we(min_we), .waddr(min_waddr), .wdata(rmin_new), .raddr(rm), .rdata(ram_m)
  );

  // Forwarding for a read issued in the same cycle as a write to its entry
  logic              fwd_a;
  logic              fwd_b;
  logic              fwd_m;
  logic [PATH_W-1:0] fwd_cost;
  logic [PATH_W-1:0] fwd_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_a <= 1'b0;
      fwd_b <= 1'b0;
      fwd_m <= 1'b0;
    end else begin
      fwd_a <= s1_adv && (cost_waddr == ra);
      fwd_b <= s1_adv && (cost_waddr == rb);
      fwd_m <= min_we && (min_waddr == rm);
    end
  end

  always_ff @(posedge clk) begin
    fwd_cost <= path;
    fwd_min  <= rmin_new;
  end

  // Running state of the current pixel
  logic [PATH_W-1:0] prev_a;
  logic [PATH_W-1:0] rmin;
  logic [PATH_W-1:0] last_min;
  logic [SUM_W-1:0]  best_sum;
  logic [DW-1:0]     best_idx;
  logic [PATH_W-1:0] pa;
  logic [PATH_W-1:0] pb;
  logic [PATH_W-1:0] pm;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  total;
  logic [SUM_W-1:0]  best_sum_new;
  logic [DW-1:0]     best_idx_new;

  assign pa = fwd_a ? fwd_cost : ram_a;
  assign pb = fwd_b ? fwd_cost : ram_b;
  assign pm = s1_use_prior ? (fwd_m ? fwd_min : ram_m) : last_min;

  sgmpa_path_calc u_calc (
    .cost_in(s1_cost), .pred_same(pa), .pred_next(pb), .pred_prev(prev_a),
    .pred_min(pm), .p1(p1), .p2(p2), .ctl(s1_ctl), .cost_out(path)
  );

  // Direction sum and winner-take-all
  always_comb begin
    sum_wide = (SUM_W+1)'(s1_partial) + (SUM_W+1)'(path);
    total    = sum_wide[SUM_W] ? SUM_SAT : sum_wide[SUM_W-1:0];
    if (s1_d == '0) begin
      rmin_new     = path;
      best_sum_new = total;
      best_idx_new = '0;
    end else begin
      rmin_new     = (path < rmin) ? path : rmin;
      best_sum_new = best_sum;
      best_idx_new = best_idx;
      if (total < best_sum) begin
        best_sum_new = total;
        best_idx_new = s1_d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rmin     <= '0;
      last_min <= '0;
      best_sum <= '0;
      best_idx <= '0;
    end else if (s1_adv) begin
      rmin     <= rmin_new;
      best_sum <= best_sum_new;
      best_idx <= best_idx_new;
      if (s1_done) last_min <= rmin_new;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) prev_a <= pa;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= OTW'({(s1_done ? best_idx_new : DW'(0)), s1_d, total, path});
      m_tlast <= s1_done;
    end
  end

`ifndef SYNTH
  // Best disparity is only reported on a pixel's last beat
  a_best_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[37+2*DW-1:37+DW] == '0)
    else $error("best disparity set on a beat that is not pixel done");

  // A stalled element keeps its RAM read address so the read data stays valid
  a_hold_addr: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |-> ra == s1_ra && rm == s1_rm)
    else $error("RAM read address moved under a stalled element");

  // Best disparity never exceeds the element's own index
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[37+2*DW-1:37+DW] <= m_tdata[37+DW-1:37])
    else $error("best disparity beyond last disparity");
`endif

endmodule
`default_nettype wire
